>>> hdl/nec_rx_pkg.sv
// Shared types and constants for the NEC infrared frame receiver.
`timescale 1ns / 1ps

package nec_rx_pkg;

  // Field widths
  localparam int unsigned CaptureWidth = 16;
  localparam int unsigned PulseWidth   = 15;
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned FrameBits    = 32;
  localparam int unsigned CountWidth   = $clog2(FrameBits);

  // Pulse classes, as reported on the result channel
  typedef enum logic [1:0] {
    CLS_ZERO  = 2'd0,
    CLS_ONE   = 2'd1,
    CLS_START = 2'd2,
    CLS_ERROR = 2'd3
  } pulse_class_e;

  // Threshold register indexes
  localparam logic [CfgIdxWidth-1:0] CfgBitMin   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgZeroMax  = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgOneMax   = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgStartMin = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgStartMax = 3'd4;

  // Threshold reset values in half-ticks
  localparam logic [PulseWidth-1:0] RstBitMin   = 15'd100;
  localparam logic [PulseWidth-1:0] RstZeroMax  = 15'd800;
  localparam logic [PulseWidth-1:0] RstOneMax   = 15'd1600;
  localparam logic [PulseWidth-1:0] RstStartMin = 15'd6000;
  localparam logic [PulseWidth-1:0] RstStartMax = 15'd7500;

  // Threshold set handed to the classifier
  typedef struct packed {
    logic [PulseWidth-1:0] bit_min;
    logic [PulseWidth-1:0] zero_max;
    logic [PulseWidth-1:0] one_max;
    logic [PulseWidth-1:0] start_min;
    logic [PulseWidth-1:0] start_max;
  } thresh_t;

endpackage

>>> hdl/nec_rx_classify.sv
// Pulse width measurement and classification against the thresholds.
`timescale 1ns / 1ps

module nec_rx_classify
  import nec_rx_pkg::*;
(
  input  logic [CaptureWidth-1:0] capture_i,
  input  logic [CaptureWidth-1:0] prev_capture_i,
  input  thresh_t                 thresh_i,
  output pulse_class_e            class_o
);

  logic [CaptureWidth-1:0] diff;
  logic [PulseWidth-1:0]   width;
  logic                    is_zero;
  logic                    is_one;
  logic                    is_start;

  // Wrapped difference, halved
  assign diff  = capture_i - prev_capture_i;
  assign width = diff[CaptureWidth-1:1];

  // Range tests; an inverted range never matches
  assign is_zero  = (width >= thresh_i.bit_min) && (width <= thresh_i.zero_max);
  assign is_one   = (width >= thresh_i.bit_min) && (width <= thresh_i.one_max);
  assign is_start = (width >= thresh_i.start_min) && (width <= thresh_i.start_max);

  // Resolve overlaps in priority order
  always_comb begin
    if (is_zero) begin
      class_o = CLS_ZERO;
    end else if (is_one) begin
      class_o = CLS_ONE;
    end else if (is_start) begin
      class_o = CLS_START;
    end else begin
      class_o = CLS_ERROR;
    end
  end

endmodule

>>> hdl/nec_ir_frame_receiver_top.sv
// Top level of the NEC infrared frame receiver: capture register, frame state, result register.
// Path: an accepted capture beat waits in the capture register, then goes to the result register.
// Throughput: one capture per cycle while results are taken; the classifier and frame shift
// sit in one register stage. Both stages advance together under output back-pressure, so a
// full pipe still takes a beat in the cycle the result is taken.
// Reset: thresholds return to 100/800/1600/6000/7500, frame, bit count and last capture clear.
`timescale 1ns / 1ps

module nec_ir_frame_receiver_top
  import nec_rx_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write channel
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [PulseWidth-1:0]   cfg_data_i,
  // Capture channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CaptureWidth-1:0] capture_time_i,
  // Result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              pulse_class_o,
  output logic                    frame_done_o,
  output logic [7:0]              address_byte_o,
  output logic [7:0]              command_byte_o,
  output logic                    command_ok_o
);

  thresh_t                 thresh_q;
  logic                    cap_valid_q;
  logic [CaptureWidth-1:0] cap_q;
  logic                    out_valid_q;
  logic [CaptureWidth-1:0] prev_q;
  logic [FrameBits-1:0]    shift_q;
  logic [CountWidth-1:0]   count_q;

  logic                    out_load;
  logic                    in_fire;
  pulse_class_e            cls;
  logic                    is_bit;
  logic                    done;
  logic [FrameBits-1:0]    shift_d;
  logic [CountWidth-1:0]   count_d;

  // Threshold registers; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.bit_min   <= RstBitMin;
      thresh_q.zero_max  <= RstZeroMax;
      thresh_q.one_max   <= RstOneMax;
      thresh_q.start_min <= RstStartMin;
      thresh_q.start_max <= RstStartMax;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBitMin:   thresh_q.bit_min   <= cfg_data_i;
        CfgZeroMax:  thresh_q.zero_max  <= cfg_data_i;
        CfgOneMax:   thresh_q.one_max   <= cfg_data_i;
        CfgStartMin: thresh_q.start_min <= cfg_data_i;
        CfgStartMax: thresh_q.start_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipe handshake: result register frees when empty or taken
  assign out_load   = cap_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !cap_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Capture register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      cap_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cap_q <= capture_time_i;
    end
  end

  // Classify the held capture
  nec_rx_classify u_classify (
    .capture_i      (cap_q),
    .prev_capture_i (prev_q),
    .thresh_i       (thresh_q),
    .class_o        (cls)
  );

  // Next frame state
  assign is_bit = (cls == CLS_ZERO) || (cls == CLS_ONE);
  assign done   = is_bit && (count_q == CountWidth'(FrameBits - 1));

  always_comb begin
    shift_d = shift_q;
    count_d = count_q;
    case (cls)
      CLS_ZERO, CLS_ONE: begin
        shift_d = {(cls == CLS_ONE), shift_q[FrameBits-1:1]};
        count_d = done ? '0 : count_q + 1'b1;
      end
      CLS_START: begin
        shift_d = '0;
        count_d = '0;
      end
      default: begin
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      shift_q <= '0;
      count_q <= '0;
    end else if (out_load) begin
      prev_q  <= cap_q;
      shift_q <= shift_d;
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pulse_class_o  <= cls;
      frame_done_o   <= done;
      address_byte_o <= done ? shift_d[7:0] : 8'h00;
      command_byte_o <= done ? shift_d[23:16] : 8'h00;
      command_ok_o   <= done && (shift_d[23:16] == ~shift_d[31:24]);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> bench/nec_ir_frame_receiver_top_test.sv
// Self-checking testbench for the NEC infrared frame receiver: edge stimulus and result checks.
`timescale 1ns / 1ps

module nec_ir_frame_receiver_top_test;
  import nec_rx_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 750;

  // One result beat as the block reports it
  typedef struct packed {
    logic [1:0] pulse_class;
    logic       frame_done;
    logic [7:0] address_byte;
    logic [7:0] command_byte;
    logic       command_ok;
  } ir_result_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_valid_i    = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxWidth-1:0]  cfg_index_i    = '0;
  logic [PulseWidth-1:0]   cfg_data_i     = '0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_ready_o;
  logic [CaptureWidth-1:0] capture_time_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i    = 1'b0;
  logic [1:0]              pulse_class_o;
  logic                    frame_done_o;
  logic [7:0]              address_byte_o;
  logic [7:0]              command_byte_o;
  logic                    command_ok_o;

  // Decoder state mirrored on the bench side
  thresh_t           thresh_model;
  logic [15:0]       last_edge_model = '0;
  logic [31:0]       frame_model     = '0;
  logic [5:0]        bit_count_model = '0;
  ir_result_t        pending_results[$];

  // Stimulus bookkeeping
  logic [15:0]       last_sent   = '0;
  int unsigned       sent_count  = 0;
  int unsigned       burst_left  = 0;
  bit                gaps_on     = 1'b1;
  int unsigned       fail_count  = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       ready_cycle = 0;
  int unsigned       stall_left  = 0;

  nec_ir_frame_receiver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .capture_time_i (capture_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pulse_class_o  (pulse_class_o),
    .frame_done_o   (frame_done_o),
    .address_byte_o (address_byte_o),
    .command_byte_o (command_byte_o),
    .command_ok_o   (command_ok_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Classify a half-tick width; earlier ranges win on overlap
  function automatic pulse_class_e classify_width(input logic [14:0] w);
    if (w >= thresh_model.bit_min && w <= thresh_model.zero_max) return CLS_ZERO;
    if (w >= thresh_model.bit_min && w <= thresh_model.one_max) return CLS_ONE;
    if (w >= thresh_model.start_min && w <= thresh_model.start_max) return CLS_START;
    return CLS_ERROR;
  endfunction

  // Advance the mirrored decoder by one edge and queue the result it gives
  task automatic decode_edge(input logic [15:0] stamp);
    logic [15:0]  delta;
    pulse_class_e cls;
    ir_result_t   res;
    delta = stamp - last_edge_model;
    cls = classify_width(delta[15:1]);
    res = '0;
    res.pulse_class = cls;
    last_edge_model = stamp;
    case (cls)
      CLS_ZERO, CLS_ONE: begin
        frame_model = {cls == CLS_ONE, frame_model[31:1]};
        bit_count_model = bit_count_model + 6'd1;
        if (bit_count_model >= FrameBits) begin
          res.frame_done   = 1'b1;
          res.address_byte = frame_model[7:0];
          res.command_byte = frame_model[23:16];
          res.command_ok   = (frame_model[23:16] == ~frame_model[31:24]);
          bit_count_model  = '0;
        end
      end
      CLS_START: begin
        frame_model = '0;
        bit_count_model = '0;
      end
      default: bit_count_model = '0;
    endcase
    pending_results.push_back(res);
  endtask

  // Offer one capture beat, hold it until taken, then maybe open a gap
  task automatic send_capture(input logic [15:0] stamp);
    bit taken;
    in_valid_i <= 1'b1;
    capture_time_i <= stamp;
    last_sent = stamp;
    sent_count++;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      if (taken) decode_edge(stamp);
      @(posedge clk_i);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  // Send the next edge so the pulse has the given half-tick width
  task automatic send_width(input logic [14:0] w);
    logic [15:0] stamp;
    stamp = last_sent + {w, 1'b0} + 16'($urandom_range(0, 1));
    send_capture(stamp);
  endtask

  // Width inside a class's range under current thresholds; any width for error or empty range
  function automatic logic [14:0] pick_width(input pulse_class_e cls);
    int lo;
    int hi;
    lo = 0;
    hi = 32767;
    case (cls)
      CLS_ZERO: begin
        lo = thresh_model.bit_min;
        hi = thresh_model.zero_max;
      end
      CLS_ONE: begin
        lo = (thresh_model.zero_max + 1 > thresh_model.bit_min) ?
             thresh_model.zero_max + 1 : thresh_model.bit_min;
        hi = thresh_model.one_max;
      end
      CLS_START: begin
        lo = thresh_model.start_min;
        hi = thresh_model.start_max;
      end
      default: ;
    endcase
    if (lo > hi) return 15'($urandom_range(0, 32767));
    return 15'($urandom_range(hi, lo));
  endfunction

  function automatic logic [14:0] cap15(input int v);
    return (v > 32767) ? 15'd32767 : 15'(v);
  endfunction

  // Hold off the sender until every queued result has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write one register; the caller drops cfg_valid_i after the last write
  task automatic write_threshold(input logic [CfgIdxWidth-1:0] idx,
                                 input logic [PulseWidth-1:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    case (idx)
      CfgBitMin:   thresh_model.bit_min   = value;
      CfgZeroMax:  thresh_model.zero_max  = value;
      CfgOneMax:   thresh_model.one_max   = value;
      CfgStartMin: thresh_model.start_min = value;
      CfgStartMax: thresh_model.start_max = value;
      default: ;
    endcase
  endtask

  // Reload all thresholds on an idle block, with a stray write to an unused index
  task automatic program_thresholds(input logic [14:0] bit_min, input logic [14:0] zero_max,
                                    input logic [14:0] one_max, input logic [14:0] start_min,
                                    input logic [14:0] start_max);
    drain_results();
    write_threshold(CfgIdxWidth'($urandom_range(5, 7)), PulseWidth'($urandom));
    write_threshold(CfgBitMin, bit_min);
    write_threshold(CfgZeroMax, zero_max);
    write_threshold(CfgOneMax, one_max);
    write_threshold(CfgStartMin, start_min);
    write_threshold(CfgStartMax, start_max);
    cfg_valid_i <= 1'b0;
  endtask

  // Compare one result field
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Check each result beat against the oldest expectation
  always @(negedge clk_i) begin : check_results
    ir_result_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual class %0d",
                 $time, pulse_class_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("pulse_class", 8'(want.pulse_class), 8'(pulse_class_o));
        check_field("frame_done", 8'(want.frame_done), 8'(frame_done_o));
        check_field("address_byte", want.address_byte, address_byte_o);
        check_field("command_byte", want.command_byte, command_byte_o);
        check_field("command_ok", 8'(want.command_ok), 8'(command_ok_o));
      end
    end
  end

  // End the run when no channel moves a beat for too long
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL nec_ir_frame_receiver_top");
      $finish;
    end
  end

  // Result back-pressure: full rate, short frequent stalls, long rare stalls
  always @(posedge clk_i) begin
    ready_cycle++;
    if (stall_left != 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      case ((ready_cycle / 300) % 3)
        0: ;
        1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
        default: if ($urandom_range(0, 40) == 0) stall_left = $urandom_range(10, 30);
      endcase
    end
  end

  // Reset thresholds: every class boundary, wrap-around and the extreme captures
  task automatic test_reset_thresholds();
    send_capture(16'hFFFF);
    send_capture(16'h0000);
    send_width(15'd100);
    send_width(15'd800);
    send_width(15'd801);
    send_width(15'd1600);
    send_width(15'd99);
    send_width(15'd1601);
    send_width(15'd5999);
    send_width(15'd6000);
    send_width(15'd7500);
    send_width(15'd7501);
  endtask

  // Zeroed, saturated, inverted and overlapping threshold sets
  task automatic test_threshold_extremes();
    program_thresholds('0, '0, '0, '0, '0);
    send_width(15'd0);
    send_width(15'd1);
    send_width(15'd32767);
    program_thresholds('1, '1, '1, '1, '1);
    send_width(15'd32767);
    send_width(15'd32766);
    program_thresholds(15'd32767, 15'd0, 15'd0, 15'd32767, 15'd0);
    send_width(15'd0);
    send_width(15'd16000);
    program_thresholds(15'd0, 15'd500, 15'd300, 15'd200, 15'd32767);
    send_width(15'd400);
    send_width(15'd1000);
    send_width(15'd32767);
  endtask

  // One frame: usually a start mark and 32 bits, with noise and broken sequences mixed in
  task automatic send_frame(input bit pause_mid);
    logic [7:0]  addr;
    logic [7:0]  cmd;
    logic [31:0] word;
    int unsigned roll;
    addr = 8'($urandom);
    cmd = 8'($urandom);
    word = ($urandom_range(0, 1) == 1) ? {~cmd, cmd, ~addr, addr} : $urandom;
    if ($urandom_range(0, 9) != 0) send_width(pick_width(CLS_START));
    for (int i = 0; i < 32; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) send_width(pick_width(CLS_ERROR));
      else if (roll < 5) send_capture(16'($urandom));
      else send_width(pick_width(word[i] ? CLS_ONE : CLS_ZERO));
      if (pause_mid && i == 15) drain_results();
    end
    // Run on past the frame end so bits keep shifting into the kept frame
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 8)) send_width(pick_width(($urandom_range(0, 1) == 1) ?
                                                           CLS_ONE : CLS_ZERO));
    end
  endtask

  // Random frames under a rotating set of threshold settings
  task automatic test_random_frames();
    int unsigned first;
    int unsigned phase;
    int          bm;
    int          zm;
    int          om;
    int          smin;
    first = sent_count;
    phase = 0;
    while (sent_count - first < RandomItems) begin
      bm = $urandom_range(0, 2000);
      zm = bm + $urandom_range(0, 3000);
      om = zm + $urandom_range(1, 3000);
      smin = om + $urandom_range(1, 5000);
      case (phase % 5)
        0: program_thresholds(RstBitMin, RstZeroMax, RstOneMax, RstStartMin, RstStartMax);
        1, 2: program_thresholds(cap15(bm), cap15(zm), cap15(om), cap15(smin),
                                 cap15(smin + $urandom_range(0, 8000)));
        3: program_thresholds(15'($urandom), 15'($urandom), 15'($urandom),
                              15'($urandom), 15'($urandom));
        default: program_thresholds('0, cap15(zm), cap15(om), cap15(smin), '1);
      endcase
      gaps_on = (phase % 3 != 1);
      for (int f = 0; f < 3; f++) send_frame(f == 1 && phase % 2 == 0);
      phase++;
    end
  endtask

  initial begin
    thresh_model = {RstBitMin, RstZeroMax, RstOneMax, RstStartMin, RstStartMax};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_thresholds();
    test_threshold_extremes();
    test_random_frames();
    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) $display("PASS nec_ir_frame_receiver_top");
    else $display("FAIL nec_ir_frame_receiver_top");
    $finish;
  end

endmodule

>>> filelist.f
hdl/nec_rx_pkg.sv
hdl/nec_rx_classify.sv
hdl/nec_ir_frame_receiver_top.sv
bench/nec_ir_frame_receiver_top_test.sv
